// ===== hdl/indexed_doubly_linked_lists_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DOUBLY_LINKED_LISTS_DEFINES_SVH
`define INDEXED_DOUBLY_LINKED_LISTS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IDLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/idll_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: package
// Field widths, command codes, datapath operation codes and the command and
// status structures between controller and datapath.
// ----------------------------------------------------------------------------
package idll_pkg;

  localparam int CMD_W  = 2;
  localparam int ELEM_W = 8;
  localparam int LIST_W = 4;
  localparam int LEN_W  = 9;

  localparam int DEF_NUM_ELEMENTS = 256;
  localparam int DEF_NUM_LISTS    = 16;

  localparam logic [CMD_W-1:0] CMD_APPEND    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 2'd3;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_INIT    = 4'd1;
  localparam logic [OP_W-1:0] OP_CAPTURE = 4'd2;
  localparam logic [OP_W-1:0] OP_A_RD    = 4'd3;
  localparam logic [OP_W-1:0] OP_A_LINK  = 4'd4;
  localparam logic [OP_W-1:0] OP_A_ELEM  = 4'd5;
  localparam logic [OP_W-1:0] OP_R_RD    = 4'd6;
  localparam logic [OP_W-1:0] OP_R_LINK  = 4'd7;
  localparam logic [OP_W-1:0] OP_R_ELEM  = 4'd8;
  localparam logic [OP_W-1:0] OP_C_RD    = 4'd9;
  localparam logic [OP_W-1:0] OP_C_START = 4'd10;
  localparam logic [OP_W-1:0] OP_C_WALK  = 4'd11;
  localparam logic [OP_W-1:0] OP_C_FIN   = 4'd12;
  localparam logic [OP_W-1:0] OP_Q_RD    = 4'd13;
  localparam logic [OP_W-1:0] OP_Q_OUT   = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             list_ok;
    logic             elem_ok;
    logic             walk_more;
    logic             last_list;
    logic             init_last;
    logic             out_free;
  } dp_status_t;

endpackage

// ===== hdl/idll_ifs.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface idll_in_if;
  import idll_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ELEM_W-1:0] element;
  logic [LIST_W-1:0] list_index;

  modport source (output valid, cmd, element, list_index, input ready);
  modport sink   (input valid, cmd, element, list_index, output ready);
endinterface

interface idll_out_if;
  import idll_pkg::*;

  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  list_length;
  logic [ELEM_W-1:0] first_element;
  logic [ELEM_W-1:0] last_element;
  logic              list_empty;

  modport source (output valid, list_length, first_element, last_element, list_empty,
                  input ready);
  modport sink   (input valid, list_length, first_element, last_element, list_empty,
                  output ready);
endinterface

// ===== hdl/idll_dp.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: datapath
// Link tables, member counters, walk registers and the result register.
// ----------------------------------------------------------------------------
module idll_dp #(
  parameter int NUM_ELEMENTS = idll_pkg::DEF_NUM_ELEMENTS,
  parameter int NUM_LISTS    = idll_pkg::DEF_NUM_LISTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  idll_pkg::dp_cmd_t             cmd_i,
  output idll_pkg::dp_status_t          st_o,
  input  logic [idll_pkg::CMD_W-1:0]    in_cmd,
  input  logic [idll_pkg::ELEM_W-1:0]   in_element,
  input  logic [idll_pkg::LIST_W-1:0]   in_list_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [idll_pkg::LEN_W-1:0]    out_list_length,
  output logic [idll_pkg::ELEM_W-1:0]   out_first_element,
  output logic [idll_pkg::ELEM_W-1:0]   out_last_element,
  output logic                          out_list_empty
);
  import idll_pkg::*;

  localparam int NODE_COUNT = NUM_ELEMENTS + NUM_LISTS;
  localparam int NW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(NUM_ELEMENTS + 1);
  localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  logic [NW-1:0] next_mem [NODE_COUNT];
  logic [NW-1:0] prev_mem [NODE_COUNT];
  logic [CW-1:0] cnt_mem  [NUM_LISTS];

  logic [CMD_W-1:0]  cmd_r;
  logic [ELEM_W-1:0] elem_r;
  logic [LIST_W-1:0] list_r;
  logic [LW-1:0]     clr_list_r;
  logic [NW-1:0]     cur_r;
  logic [CW-1:0]     steps_r;
  logic [NW-1:0]     init_idx_r;
  logic [NW-1:0]     next_rd_r;
  logic [NW-1:0]     prev_rd_r;
  logic [CW-1:0]     cnt_rd_r;
  logic              out_valid_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [ELEM_W-1:0] out_first_r;
  logic [ELEM_W-1:0] out_last_r;
  logic              out_empty_r;

  logic          list_ok;
  logic          elem_ok;
  logic [NW-1:0] elem_node;
  logic [LW-1:0] list_sel;
  logic [NW-1:0] head_node;
  logic [NW-1:0] clr_head;

  logic          next_we, next_re, prev_we, prev_re, cnt_we, cnt_re;
  logic [NW-1:0] next_wa, next_wd, next_ra, prev_wa, prev_wd, prev_ra;
  logic [LW-1:0] cnt_wa, cnt_ra;
  logic [CW-1:0] cnt_wd;

  assign list_ok   = 32'(list_r) < NUM_LISTS;
  assign elem_ok   = 32'(elem_r) < NUM_ELEMENTS;
  assign elem_node = NW'(elem_r);
  assign list_sel  = LW'(list_r);
  assign head_node = NW'(NUM_ELEMENTS) + NW'(list_r);
  assign clr_head  = NW'(NUM_ELEMENTS) + NW'(clr_list_r);

  assign st_o.cmd       = cmd_r;
  assign st_o.list_ok   = list_ok;
  assign st_o.elem_ok   = elem_ok;
  assign st_o.walk_more = (32'(cur_r) < NUM_ELEMENTS) && (32'(steps_r) < NUM_ELEMENTS);
  assign st_o.last_list = 32'(clr_list_r) == NUM_LISTS - 1;
  assign st_o.init_last = 32'(init_idx_r) == NODE_COUNT - 1;
  assign st_o.out_free  = !out_valid_r || out_ready;

  always_comb begin
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    next_re = 1'b0;
    next_ra = '0;
    prev_we = 1'b0;
    prev_wa = '0;
    prev_wd = '0;
    prev_re = 1'b0;
    prev_ra = '0;
    cnt_we  = 1'b0;
    cnt_wa  = '0;
    cnt_wd  = '0;
    cnt_re  = 1'b0;
    cnt_ra  = '0;
    case (cmd_i.op)
      OP_INIT: begin
        next_we = 1'b1;
        next_wa = init_idx_r;
        next_wd = init_idx_r;
        prev_we = 1'b1;
        prev_wa = init_idx_r;
        prev_wd = init_idx_r;
        cnt_we  = 32'(init_idx_r) < NUM_LISTS;
        cnt_wa  = LW'(init_idx_r);
      end
      OP_A_RD: begin
        prev_re = 1'b1;
        prev_ra = head_node;
        cnt_re  = 1'b1;
        cnt_ra  = list_sel;
      end
      OP_A_LINK: begin
        prev_we = 1'b1;
        prev_wa = head_node;
        prev_wd = elem_node;
        next_we = 1'b1;
        next_wa = prev_rd_r;
        next_wd = elem_node;
        cnt_we  = 1'b1;
        cnt_wa  = list_sel;
        cnt_wd  = (32'(cnt_rd_r) < NUM_ELEMENTS) ? cnt_rd_r + CW'(1) : cnt_rd_r;
      end
      OP_A_ELEM: begin
        prev_we = 1'b1;
        prev_wa = elem_node;
        prev_wd = prev_rd_r;
        next_we = 1'b1;
        next_wa = elem_node;
        next_wd = head_node;
      end
      OP_R_RD: begin
        prev_re = 1'b1;
        prev_ra = elem_node;
        next_re = 1'b1;
        next_ra = elem_node;
        cnt_re  = 1'b1;
        cnt_ra  = list_sel;
      end
      OP_R_LINK: begin
        next_we = 1'b1;
        next_wa = prev_rd_r;
        next_wd = next_rd_r;
        prev_we = 1'b1;
        prev_wa = next_rd_r;
        prev_wd = prev_rd_r;
        cnt_we  = 1'b1;
        cnt_wa  = list_sel;
        cnt_wd  = (cnt_rd_r != '0) ? cnt_rd_r - CW'(1) : cnt_rd_r;
      end
      OP_R_ELEM: begin
        next_we = 1'b1;
        next_wa = elem_node;
        next_wd = elem_node;
        prev_we = 1'b1;
        prev_wa = elem_node;
        prev_wd = elem_node;
      end
      OP_C_RD: begin
        next_re = 1'b1;
        next_ra = clr_head;
      end
      OP_C_START: begin
        next_re = 1'b1;
        next_ra = next_rd_r;
      end
      OP_C_WALK: begin
        next_we = 1'b1;
        next_wa = cur_r;
        next_wd = cur_r;
        prev_we = 1'b1;
        prev_wa = cur_r;
        prev_wd = cur_r;
        next_re = 1'b1;
        next_ra = next_rd_r;
      end
      OP_C_FIN: begin
        next_we = 1'b1;
        next_wa = clr_head;
        next_wd = clr_head;
        prev_we = 1'b1;
        prev_wa = clr_head;
        prev_wd = clr_head;
        cnt_we  = 1'b1;
        cnt_wa  = clr_list_r;
      end
      OP_Q_RD: begin
        next_re = 1'b1;
        next_ra = head_node;
        prev_re = 1'b1;
        prev_ra = head_node;
        cnt_re  = 1'b1;
        cnt_ra  = list_sel;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (next_re) begin
      next_rd_r <= next_mem[next_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (prev_re) begin
      prev_rd_r <= prev_mem[prev_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_r <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.op == OP_INIT) begin
        init_idx_r <= init_idx_r + NW'(1);
      end
      if (cmd_i.op == OP_Q_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        cmd_r      <= in_cmd;
        elem_r     <= in_element;
        list_r     <= in_list_index;
        clr_list_r <= (in_cmd == CMD_CLEAR) ? LW'(in_list_index) : '0;
      end
      OP_C_START: begin
        cur_r   <= next_rd_r;
        steps_r <= '0;
      end
      OP_C_WALK: begin
        cur_r   <= next_rd_r;
        steps_r <= steps_r + CW'(1);
      end
      OP_C_FIN: begin
        clr_list_r <= clr_list_r + LW'(1);
      end
      OP_Q_OUT: begin
        if (list_ok) begin
          out_len_r   <= LEN_W'(cnt_rd_r);
          out_first_r <= (32'(next_rd_r) < NUM_ELEMENTS) ? ELEM_W'(next_rd_r) : '0;
          out_last_r  <= (32'(prev_rd_r) < NUM_ELEMENTS) ? ELEM_W'(prev_rd_r) : '0;
          out_empty_r <= next_rd_r == head_node;
        end else begin
          out_len_r   <= '0;
          out_first_r <= '0;
          out_last_r  <= '0;
          out_empty_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_list_length   = out_len_r;
  assign out_first_element = out_first_r;
  assign out_last_element  = out_last_r;
  assign out_list_empty    = out_empty_r;

endmodule

// ===== hdl/idll_ctrl.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: controller
// Sequences the reset sweep, each command's table accesses and the report.
// ----------------------------------------------------------------------------
module idll_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  idll_pkg::dp_status_t st_i,
  output idll_pkg::dp_cmd_t    cmd_o
);
  import idll_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_A_LINK  = 4'd3;
  localparam logic [3:0] S_A_ELEM  = 4'd4;
  localparam logic [3:0] S_R_LINK  = 4'd5;
  localparam logic [3:0] S_R_ELEM  = 4'd6;
  localparam logic [3:0] S_C_RD    = 4'd7;
  localparam logic [3:0] S_C_START = 4'd8;
  localparam logic [3:0] S_C_WALK  = 4'd9;
  localparam logic [3:0] S_Q_RD    = 4'd10;
  localparam logic [3:0] S_Q_OUT   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd_o.op  = OP_NOP;
    case (state_r)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (st_i.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.op  = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (st_i.cmd)
          CMD_CLEAR_ALL: begin
            cmd_o.op  = OP_C_RD;
            state_nxt = S_C_START;
          end
          CMD_CLEAR: begin
            if (st_i.list_ok) begin
              cmd_o.op  = OP_C_RD;
              state_nxt = S_C_START;
            end else begin
              state_nxt = S_Q_OUT;
            end
          end
          CMD_APPEND: begin
            if (!st_i.list_ok) begin
              state_nxt = S_Q_OUT;
            end else if (st_i.elem_ok) begin
              cmd_o.op  = OP_A_RD;
              state_nxt = S_A_LINK;
            end else begin
              cmd_o.op  = OP_Q_RD;
              state_nxt = S_Q_OUT;
            end
          end
          CMD_REMOVE: begin
            if (!st_i.list_ok) begin
              state_nxt = S_Q_OUT;
            end else if (st_i.elem_ok) begin
              cmd_o.op  = OP_R_RD;
              state_nxt = S_R_LINK;
            end else begin
              cmd_o.op  = OP_Q_RD;
              state_nxt = S_Q_OUT;
            end
          end
          default: begin
            state_nxt = S_Q_OUT;
          end
        endcase
      end
      S_A_LINK: begin
        cmd_o.op  = OP_A_LINK;
        state_nxt = S_A_ELEM;
      end
      S_A_ELEM: begin
        cmd_o.op  = OP_A_ELEM;
        state_nxt = S_Q_RD;
      end
      S_R_LINK: begin
        cmd_o.op  = OP_R_LINK;
        state_nxt = S_R_ELEM;
      end
      S_R_ELEM: begin
        cmd_o.op  = OP_R_ELEM;
        state_nxt = S_Q_RD;
      end
      S_C_RD: begin
        cmd_o.op  = OP_C_RD;
        state_nxt = S_C_START;
      end
      S_C_START: begin
        cmd_o.op  = OP_C_START;
        state_nxt = S_C_WALK;
      end
      S_C_WALK: begin
        if (st_i.walk_more) begin
          cmd_o.op = OP_C_WALK;
        end else begin
          cmd_o.op = OP_C_FIN;
          if (st_i.cmd == CMD_CLEAR_ALL && !st_i.last_list) begin
            state_nxt = S_C_RD;
          end else if (st_i.list_ok) begin
            state_nxt = S_Q_RD;
          end else begin
            state_nxt = S_Q_OUT;
          end
        end
      end
      S_Q_RD: begin
        cmd_o.op  = OP_Q_RD;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (st_i.out_free) begin
          cmd_o.op  = OP_Q_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/indexed_doubly_linked_lists.sv =====
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: top level
// Circular doubly linked lists over a fixed element pool, with one sentinel
// node per list, link tables in memories and a member counter per list.
// ----------------------------------------------------------------------------
// Append and remove read links and counter, relink, then read the report; a
// plain report reads at most the sentinel links and counter. Clearing walks each
// list's members along the next links, then resets its sentinel and counter.
// A result word is loaded only once the result register is free.
// After reset a sweep of all NUM_ELEMENTS + NUM_LISTS nodes initializes the link
// tables and counters; no word is accepted until it completes.
`include "indexed_doubly_linked_lists_defines.svh"

module indexed_doubly_linked_lists #(
  parameter int NUM_ELEMENTS = idll_pkg::DEF_NUM_ELEMENTS,
  parameter int NUM_LISTS    = idll_pkg::DEF_NUM_LISTS
) (
  input  logic       clk,
  input  logic       rst_n,
  idll_in_if.sink    in_ch,
  idll_out_if.source out_ch
);
  import idll_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;

  idll_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st_i     (dp_st),
    .cmd_o    (dp_cmd)
  );

  idll_dp #(
    .NUM_ELEMENTS (NUM_ELEMENTS),
    .NUM_LISTS    (NUM_LISTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_i             (dp_cmd),
    .st_o              (dp_st),
    .in_cmd            (in_ch.cmd),
    .in_element        (in_ch.element),
    .in_list_index     (in_ch.list_index),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_list_length   (out_ch.list_length),
    .out_first_element (out_ch.first_element),
    .out_last_element  (out_ch.last_element),
    .out_list_empty    (out_ch.list_empty)
  );

  `IDLL_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after accept")
  `IDLL_ASSERT_NOW(a_load_when_free, dp_cmd.op == OP_Q_OUT, dp_st.out_free, "result overwritten")
  `IDLL_ASSERT_NOW(a_valid_from_load, $rose(out_ch.valid), $past(dp_cmd.op) == OP_Q_OUT, "stray result")
  `IDLL_ASSERT_NOW(a_no_accept_in_init, dp_cmd.op == OP_INIT, !in_ch.ready, "ready during init sweep")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed doubly linked lists: self-checking testbench
// Drives append, remove, clear and clear-all command words with random gaps
// and random result back-pressure. A local copy of the link tables and member
// counters predicts each reported length, head, tail and empty flag unless a
// plan row pins it; each result word is compared against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
  import idll_pkg::*;

  localparam int N_ELEM      = DEF_NUM_ELEMENTS;
  localparam int N_LIST      = DEF_NUM_LISTS;
  localparam int N_NODE      = N_ELEM + N_LIST;
  localparam int NODE_W      = 9;
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 32;

  typedef logic [NODE_W-1:0] node_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [ELEM_W-1:0] head_elem;
    logic [ELEM_W-1:0] tail_elem;
    logic              is_empty;
  } list_report_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] elem;
    logic [LIST_W-1:0] lst;
    logic              pinned;
    list_report_t      rep;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  idll_in_if  in_ch ();
  idll_out_if out_ch ();

  indexed_doubly_linked_lists dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  node_t            link_fwd  [N_NODE];
  node_t            link_back [N_NODE];
  logic [LEN_W-1:0] list_size [N_LIST];

  list_report_t pending_reports[$];
  plan_row_t    plan[$];
  int           owner[N_ELEM];

  bit           in_taken;
  bit           out_taken;
  bit           in_calm;
  bit           out_calm;
  bit           timed_out;
  bit           drv_pinned;
  list_report_t drv_pinned_rep;
  int           quiet_cycles;
  int           mismatches;

  function automatic node_t on_table(input node_t x);
    return (x < node_t'(N_NODE)) ? x : '0;
  endfunction

  function automatic void empty_out(input int lst);
    node_t head;
    node_t cur;
    node_t nxt;
    int    steps;
    head  = node_t'(N_ELEM + lst);
    cur   = on_table(link_fwd[head]);
    steps = 0;
    while (cur < node_t'(N_ELEM) && steps < N_ELEM) begin
      nxt            = on_table(link_fwd[cur]);
      link_fwd[cur]  = cur;
      link_back[cur] = cur;
      cur            = nxt;
      steps++;
    end
    link_fwd[head]  = head;
    link_back[head] = head;
    list_size[lst]  = '0;
  endfunction

  function automatic list_report_t update_lists(input logic [CMD_W-1:0] c,
                                                input logic [ELEM_W-1:0] e,
                                                input logic [LIST_W-1:0] l);
    list_report_t rep;
    node_t        head;
    node_t        elem;
    node_t        tail;
    node_t        prior;
    node_t        later;
    head = node_t'(N_ELEM) + node_t'(l);
    elem = node_t'(e);
    if (c == CMD_CLEAR_ALL) begin
      for (int i = 0; i < N_LIST; i++) empty_out(i);
    end else if (c == CMD_CLEAR) begin
      empty_out(int'(l));
    end else if (c == CMD_APPEND) begin
      tail            = on_table(link_back[head]);
      link_back[head] = elem;
      link_back[elem] = tail;
      link_fwd[tail]  = elem;
      link_fwd[elem]  = head;
      if (list_size[l] < LEN_W'(N_ELEM)) list_size[l] = list_size[l] + 1'b1;
    end else begin
      prior            = on_table(link_back[elem]);
      later            = on_table(link_fwd[elem]);
      link_fwd[prior]  = later;
      link_back[later] = prior;
      link_fwd[elem]   = elem;
      link_back[elem]  = elem;
      if (list_size[l] > 0) list_size[l] = list_size[l] - 1'b1;
    end
    prior         = on_table(link_fwd[head]);
    later         = on_table(link_back[head]);
    rep.len       = list_size[l];
    rep.head_elem = (prior < node_t'(N_ELEM)) ? ELEM_W'(prior) : '0;
    rep.tail_elem = (later < node_t'(N_ELEM)) ? ELEM_W'(later) : '0;
    rep.is_empty  = (prior == head);
    return rep;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    list_report_t want;
    if (!rst_n) begin
      in_taken  = 1'b0;
      out_taken = 1'b0;
    end else begin
      in_taken  = in_ch.valid && in_ch.ready;
      out_taken = out_ch.valid && out_ch.ready;
      if (in_taken) begin
        want = update_lists(in_ch.cmd, in_ch.element, in_ch.list_index);
        pending_reports.push_back(drv_pinned ? drv_pinned_rep : want);
      end
      if (out_taken) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("result word arrived with nothing expected");
        end else begin
          want = pending_reports.pop_front();
          if (out_ch.list_length !== want.len)
            report_mismatch($sformatf("list_length %0d, expected %0d",
                                      out_ch.list_length, want.len));
          if (out_ch.first_element !== want.head_elem)
            report_mismatch($sformatf("first_element %0d, expected %0d",
                                      out_ch.first_element, want.head_elem));
          if (out_ch.last_element !== want.tail_elem)
            report_mismatch($sformatf("last_element %0d, expected %0d",
                                      out_ch.last_element, want.tail_elem));
          if (out_ch.list_empty !== want.is_empty)
            report_mismatch($sformatf("list_empty %0b, expected %0b",
                                      out_ch.list_empty, want.is_empty));
        end
      end
      if (in_taken || out_taken) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_taken);
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] c, input logic [ELEM_W-1:0] e,
                           input logic [LIST_W-1:0] l, input logic pinned,
                           input list_report_t rep);
    int gap;
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.element    <= e;
    in_ch.list_index <= l;
    drv_pinned     = pinned;
    drv_pinned_rep = rep;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic issue(input logic [CMD_W-1:0] c, input int e, input int l);
    send_word(c, ELEM_W'(e), LIST_W'(l), 1'b0, '0);
  endtask

  function automatic void add_row(input logic [CMD_W-1:0] c, input int e, input int l,
                                  input bit pinned, input int len, input int hd,
                                  input int tl, input bit emp);
    plan_row_t row;
    row.cmd           = c;
    row.elem          = ELEM_W'(e);
    row.lst           = LIST_W'(l);
    row.pinned        = pinned;
    row.rep.len       = LEN_W'(len);
    row.rep.head_elem = ELEM_W'(hd);
    row.rep.tail_elem = ELEM_W'(tl);
    row.rep.is_empty  = emp;
    plan.push_back(row);
  endfunction

  function automatic int pick_elem(input bit linked);
    int cand[$];
    for (int i = 0; i < N_ELEM; i++)
      if ((owner[i] >= 0) == linked) cand.push_back(i);
    return (cand.size() == 0) ? -1 : cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic void release_list(input int lst);
    for (int i = 0; i < N_ELEM; i++)
      if (owner[i] == lst || lst < 0) owner[i] = -1;
  endfunction

  task automatic run_mixed(input int words);
    int r;
    int e;
    int lst;
    repeat (words) begin
      r   = $urandom_range(0, 99);
      lst = ($urandom_range(0, 3) == 0) ? $urandom_range(0, N_LIST - 1)
                                        : $urandom_range(0, 3);
      if (r < 3) begin
        e = $urandom_range(0, N_ELEM - 1);
        owner[e] = lst;
        issue(CMD_APPEND, e, lst);
      end else if (r < 6) begin
        e = $urandom_range(0, N_ELEM - 1);
        owner[e] = -1;
        issue(CMD_REMOVE, e, lst);
      end else if (r < 8) begin
        e = pick_elem(1'b1);
        if (e < 0) e = $urandom_range(0, N_ELEM - 1);
        else lst = (owner[e] + $urandom_range(1, N_LIST - 1)) % N_LIST;
        owner[e] = -1;
        issue(CMD_REMOVE, e, lst);
      end else if (r < 11) begin
        release_list(lst);
        issue(CMD_CLEAR, $urandom_range(0, N_ELEM - 1), lst);
      end else if (r < 12) begin
        release_list(-1);
        issue(CMD_CLEAR_ALL, $urandom_range(0, N_ELEM - 1), lst);
      end else if (pick_elem(1'b1) < 0 || (pick_elem(1'b0) >= 0 && r < 60)) begin
        e = pick_elem(1'b0);
        owner[e] = lst;
        issue(CMD_APPEND, e, lst);
      end else begin
        e = pick_elem(1'b1);
        issue(CMD_REMOVE, e, owner[e]);
        owner[e] = -1;
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_APPEND;
    in_ch.element    = '0;
    in_ch.list_index = '0;
    for (int i = 0; i < N_NODE; i++) begin
      link_fwd[i]  = node_t'(i);
      link_back[i] = node_t'(i);
    end
    for (int i = 0; i < N_LIST; i++) list_size[i] = '0;
    for (int i = 0; i < N_ELEM; i++) owner[i] = -1;

    fork
      begin : stimulus
        int perm[N_ELEM];
        int j;
        int tmp;
        int fill_list;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        add_row(CMD_CLEAR_ALL, 0,   0,  1, 0, 0,   0,   1);
        add_row(CMD_CLEAR,     0,   15, 1, 0, 0,   0,   1);
        add_row(CMD_REMOVE,    255, 15, 1, 0, 0,   0,   1);
        add_row(CMD_APPEND,    255, 15, 1, 1, 255, 255, 0);
        add_row(CMD_APPEND,    0,   15, 1, 2, 255, 0,   0);
        add_row(CMD_APPEND,    128, 0,  0, 0, 0,   0,   0);
        add_row(CMD_APPEND,    1,   0,  0, 0, 0,   0,   0);
        add_row(CMD_REMOVE,    255, 15, 0, 0, 0,   0,   0);
        add_row(CMD_REMOVE,    0,   15, 1, 0, 0,   0,   1);
        add_row(CMD_REMOVE,    0,   15, 1, 0, 0,   0,   1);
        add_row(CMD_APPEND,    170, 7,  0, 0, 0,   0,   0);
        add_row(CMD_APPEND,    85,  7,  0, 0, 0,   0,   0);
        add_row(CMD_APPEND,    254, 7,  0, 0, 0,   0,   0);
        add_row(CMD_REMOVE,    85,  7,  0, 0, 0,   0,   0);
        add_row(CMD_REMOVE,    254, 7,  0, 0, 0,   0,   0);
        add_row(CMD_APPEND,    128, 3,  0, 0, 0,   0,   0);
        add_row(CMD_REMOVE,    1,   9,  0, 0, 0,   0,   0);
        add_row(CMD_REMOVE,    200, 2,  0, 0, 0,   0,   0);
        add_row(CMD_CLEAR,     0,   7,  0, 0, 0,   0,   0);
        add_row(CMD_CLEAR,     0,   0,  0, 0, 0,   0,   0);
        add_row(CMD_CLEAR_ALL, 0,   3,  1, 0, 0,   0,   1);
        add_row(CMD_APPEND,    0,   0,  0, 0, 0,   0,   0);
        add_row(CMD_APPEND,    255, 15, 0, 0, 0,   0,   0);
        add_row(CMD_CLEAR_ALL, 255, 15, 1, 0, 0,   0,   1);
        foreach (plan[i])
          send_word(plan[i].cmd, plan[i].elem, plan[i].lst, plan[i].pinned, plan[i].rep);

        run_mixed(1200);

        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);

        // Fill one list with the whole pool, then push its counter to the limit.
        release_list(-1);
        issue(CMD_CLEAR_ALL, $urandom_range(0, N_ELEM - 1), $urandom_range(0, N_LIST - 1));
        for (int i = 0; i < N_ELEM; i++) perm[i] = i;
        for (int i = N_ELEM - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        fill_list = $urandom_range(0, N_LIST - 1);
        for (int i = 0; i < N_ELEM; i++) issue(CMD_APPEND, perm[i], fill_list);
        issue(CMD_REMOVE, perm[N_ELEM - 1], fill_list);
        issue(CMD_APPEND, perm[N_ELEM - 1], fill_list);
        issue(CMD_APPEND, perm[$urandom_range(0, N_ELEM - 1)], fill_list);
        issue(CMD_CLEAR, $urandom_range(0, N_ELEM - 1), fill_list);
        issue(CMD_CLEAR_ALL, $urandom_range(0, N_ELEM - 1), fill_list);

        run_mixed(300);

        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
      end
      begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any

    if (timed_out) begin
      $display("SCOREBOARD MISMATCH");
    end else if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
